### rtl/iymp_pkg.sv
package iymp_pkg;

   // line parser phases, one-hot
   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_DIGITS = 6'b000010,
      PH_POST   = 6'b000100,
      PH_SEEK   = 6'b001000,
      PH_VALUE  = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;
   localparam logic [7:0] CH_Y      = 8'h79;
   localparam logic [7:0] CH_E      = 8'h65;
   localparam logic [7:0] CH_S      = 8'h73;

   localparam logic [2:0] VALUE_LEN_MATCH = 3'd3;
   localparam logic [2:0] VALUE_LEN_SAT   = 3'd4;

   // decoded view of one text byte
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic       is_blank;
      logic       is_eol;
      logic       is_quote;
      logic       is_equals;
      logic [7:0] lower;
   } char_class_type;

   // update request from the line parser to the mask register
   typedef struct packed {
      logic commit;
      logic set_bit;
      logic flush;
   } mask_cmd_type;

   // expected letters of the value "yes"
   function automatic logic [7:0] word_char(logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = CH_Y;
         2'd1:    ch = CH_E;
         default: ch = CH_S;
      endcase
      return ch;
   endfunction

   // x*10 + d with 32-bit wraparound, as shifts and adds
   function automatic logic [31:0] mul10_add(logic [31:0] x, logic [3:0] d);
      return {x[28:0], 3'b000} + {x[30:0], 1'b0} + {28'd0, d};
   endfunction

endpackage

### rtl/index_yes_manifest_parser_unit.sv
// Path: a transferred byte enters the input register and is parsed as it leaves it; for a final byte
//   the mask is loaded into the response register at that point and shows on rsp_.
// Throughput: one byte per cycle; only a final byte waits while a response is stalled.
// Reset: synchronous, active high; parser returns to start of line, mask clears,
//   both valid flags drop and req_stall is held high while reset is asserted.
module index_yes_manifest_parser_unit #(
   parameter int ENTRY_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_selected_mask
);

   localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_final_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_mask_ff;

   logic req_xfer;
   logic s1_fire;

   iymp_pkg::char_class_type cls;
   iymp_pkg::mask_cmd_type   cmd;
   logic [IDX_W-1:0]         entry_index;
   logic [ENTRY_COUNT-1:0]   mask_next;

   // a non-final byte never touches the result register, so it always moves on;
   // a final byte must wait until the result register is free
   assign s1_fire   = s1_valid_ff && !(s1_final_ff && rsp_valid_ff && rsp_stall);
   assign req_stall = reset || (s1_valid_ff && !s1_fire);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_byte_ff  <= req_text_byte;
         s1_final_ff <= req_final_byte;
      end
   end

   // byte decode
   iymp_byte_class u_class (
      .text_byte (s1_byte_ff),
      .cls       (cls)
   );

   // line state and index accumulator
   iymp_line_fsm #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .IDX_W       (IDX_W)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_fire),
      .final_byte  (s1_final_ff),
      .cls         (cls),
      .cmd         (cmd),
      .entry_index (entry_index)
   );

   // selection mask; cleared after the final byte of each buffer
   iymp_mask_unit #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .IDX_W       (IDX_W)
   ) u_mask (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_fire),
      .cmd         (cmd),
      .entry_index (entry_index),
      .mask_next   (mask_next)
   );

   // response register: loads on a final byte, drops after its transfer
   always_comb begin
      if (s1_fire && s1_final_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_final_ff) begin
         rsp_mask_ff <= 64'(mask_next);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_selected_mask = rsp_mask_ff;

endmodule

### rtl/iymp_byte_class.sv
module iymp_byte_class (
   input  logic [7:0]              text_byte,
   output iymp_pkg::char_class_type cls
);

   always_comb begin
      cls.is_digit  = (text_byte >= iymp_pkg::CH_ZERO) && (text_byte <= iymp_pkg::CH_NINE);
      cls.digit     = text_byte[3:0];
      cls.is_blank  = (text_byte == iymp_pkg::CH_SPACE) || (text_byte == iymp_pkg::CH_TAB) ||
                      (text_byte == iymp_pkg::CH_VT) || (text_byte == iymp_pkg::CH_FF);
      cls.is_eol    = (text_byte == iymp_pkg::CH_CR) || (text_byte == iymp_pkg::CH_LF);
      cls.is_quote  = (text_byte == iymp_pkg::CH_QUOTE);
      cls.is_equals = (text_byte == iymp_pkg::CH_EQUALS);
      if ((text_byte >= iymp_pkg::CH_UPPER_A) && (text_byte <= iymp_pkg::CH_UPPER_Z)) begin
         cls.lower = text_byte + iymp_pkg::CASE_OFFSET;
      end else begin
         cls.lower = text_byte;
      end
   end

endmodule

### rtl/iymp_line_fsm.sv
module iymp_line_fsm #(
   parameter int ENTRY_COUNT = 64,
   parameter int IDX_W       = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     fire,
   input  logic                     final_byte,
   input  iymp_pkg::char_class_type cls,
   output iymp_pkg::mask_cmd_type   cmd,
   output logic [IDX_W-1:0]         entry_index
);

   iymp_pkg::phase_type phase_ff, phase_in, step_phase;
   logic [31:0] index_ff, index_in, step_index;
   logic [2:0]  len_ff, len_in, step_len;
   logic        match_ff, match_in, step_match;
   logic        commit_cur;

   always_comb begin
      step_phase = phase_ff;
      step_index = index_ff;
      step_len   = len_ff;
      step_match = match_ff;
      commit_cur = 1'b0;
      if (cls.is_eol) begin
         commit_cur = (phase_ff == iymp_pkg::PH_VALUE);
         step_phase = iymp_pkg::PH_LEAD;
         step_index = '0;
         step_len   = '0;
         step_match = 1'b1;
      end else begin
         case (phase_ff)
            iymp_pkg::PH_LEAD: begin
               if (cls.is_digit) begin
                  step_index = {28'd0, cls.digit};
                  step_phase = iymp_pkg::PH_DIGITS;
               end else if (!cls.is_blank) begin
                  step_phase = iymp_pkg::PH_SKIP;
               end
            end
            iymp_pkg::PH_DIGITS: begin
               if (cls.is_digit) begin
                  step_index = iymp_pkg::mul10_add(index_ff, cls.digit);
               end else if (cls.is_blank) begin
                  step_phase = iymp_pkg::PH_POST;
               end else if (cls.is_equals) begin
                  step_phase = (index_ff < 32'(ENTRY_COUNT)) ? iymp_pkg::PH_SEEK
                                                            : iymp_pkg::PH_SKIP;
               end else begin
                  step_phase = iymp_pkg::PH_SKIP;
               end
            end
            iymp_pkg::PH_POST: begin
               if (cls.is_equals) begin
                  step_phase = (index_ff < 32'(ENTRY_COUNT)) ? iymp_pkg::PH_SEEK
                                                            : iymp_pkg::PH_SKIP;
               end else if (!cls.is_blank) begin
                  step_phase = iymp_pkg::PH_SKIP;
               end
            end
            iymp_pkg::PH_SEEK: begin
               if (cls.is_quote) begin
                  step_len   = '0;
                  step_match = 1'b1;
                  step_phase = iymp_pkg::PH_VALUE;
               end
            end
            iymp_pkg::PH_VALUE: begin
               if (cls.is_quote) begin
                  commit_cur = 1'b1;
                  step_phase = iymp_pkg::PH_SKIP;
               end else begin
                  if ((len_ff < iymp_pkg::VALUE_LEN_MATCH) &&
                      (cls.lower != iymp_pkg::word_char(len_ff[1:0]))) begin
                     step_match = 1'b0;
                  end
                  if (len_ff < iymp_pkg::VALUE_LEN_SAT) begin
                     step_len = len_ff + 3'd1;
                  end
               end
            end
            default: begin
               step_phase = iymp_pkg::PH_SKIP;
            end
         endcase
      end
   end

   // at most one commit per byte: quote/eol uses the old value, end of buffer the new one
   always_comb begin
      cmd.flush   = final_byte;
      cmd.commit  = 1'b0;
      cmd.set_bit = 1'b0;
      if (commit_cur) begin
         cmd.commit  = 1'b1;
         cmd.set_bit = (len_ff == iymp_pkg::VALUE_LEN_MATCH) && match_ff;
      end else if (final_byte && (step_phase == iymp_pkg::PH_VALUE)) begin
         cmd.commit  = 1'b1;
         cmd.set_bit = (step_len == iymp_pkg::VALUE_LEN_MATCH) && step_match;
      end
   end

   assign entry_index = index_ff[IDX_W-1:0];

   always_comb begin
      if (final_byte) begin
         phase_in = iymp_pkg::PH_LEAD;
         index_in = '0;
         len_in   = '0;
         match_in = 1'b1;
      end else begin
         phase_in = step_phase;
         index_in = step_index;
         len_in   = step_len;
         match_in = step_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= iymp_pkg::PH_LEAD;
         index_ff <= '0;
         len_ff   <= '0;
         match_ff <= 1'b1;
      end else if (fire) begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         len_ff   <= len_in;
         match_ff <= match_in;
      end
   end

endmodule

### rtl/iymp_mask_unit.sv
module iymp_mask_unit #(
   parameter int ENTRY_COUNT = 64,
   parameter int IDX_W       = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  iymp_pkg::mask_cmd_type cmd,
   input  logic [IDX_W-1:0]       entry_index,
   output logic [ENTRY_COUNT-1:0] mask_next
);

   logic [ENTRY_COUNT-1:0] mask_ff, mask_in;

   always_comb begin
      mask_next = mask_ff;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
         if (cmd.commit && (entry_index == IDX_W'(i))) begin
            mask_next[i] = cmd.set_bit;
         end
      end
      mask_in = cmd.flush ? '0 : mask_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (fire) begin
         mask_ff <= mask_in;
      end
   end

endmodule

### rtl/iymp_port_checker.sv
module iymp_port_checker #(
   parameter int ENTRY_COUNT = 64
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_final_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_selected_mask
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_selected_mask))
      else $error("stalled response changed");

   // reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a new response follows the transfer of a final byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_final_byte, 2))
      else $error("response without final byte");

   // no bit at or above the entry count is ever set
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_selected_mask >> ENTRY_COUNT) == 64'd0))
      else $error("mask bit out of range");

endmodule

bind index_yes_manifest_parser_unit iymp_port_checker #(
   .ENTRY_COUNT (ENTRY_COUNT)
) u_port_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_final_byte    (req_final_byte),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_selected_mask (rsp_selected_mask)
);
